### sv/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// shared types and constants for the packbits run decoder
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int unsigned CountW    = 16;
    localparam int unsigned RowW      = 14;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned PatW      = 16;
    localparam int unsigned WbW       = 9;
    localparam int unsigned LitW      = 9;
    localparam int unsigned CfgIdxW   = 1;
    localparam int unsigned CfgDataW  = 14;

    localparam logic [0:0]       CfgWordUnits = 1'b0;
    localparam logic [0:0]       CfgRowLength = 1'b1;

    localparam logic             ReqStart     = 1'b0;
    localparam logic [ByteW-1:0] HdrNop       = 8'h80;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2,
        PH_WORD2   = 2'd3
    } t_phase;

    // one classified item moving from the front to the back
    typedef struct packed {
        logic              is_start;
        logic              last;
        logic [ByteW-1:0]  data;
        logic [CountW-1:0] src_left;
    } t_cmd;

endpackage

### sv/pbd_front.sv
// ----------------------------------------------------------------------------
// pbd_front
// accepts items, tracks the packed byte count and classifies each item
// ----------------------------------------------------------------------------
module pbd_front import pbd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_req_type,
    input  logic [CountW-1:0] i_packed_count,
    input  logic [ByteW-1:0]  i_packed_byte,
    input  logic              i_q_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [CountW-1:0] r_source_left;
    logic [CountW-1:0] n_source_left;
    logic              accept;
    logic              is_start;
    logic [CountW-1:0] dec_left;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign is_start   = (i_req_type == ReqStart);
    assign dec_left   = r_source_left - CountW'(1);

    always_comb begin
        n_source_left   = r_source_left;
        o_push          = 1'b0;
        o_cmd.is_start  = is_start;
        o_cmd.last      = (dec_left == '0);
        o_cmd.data      = i_packed_byte;
        o_cmd.src_left  = dec_left;
        if (accept) begin
            if (is_start) begin
                n_source_left = i_packed_count;
                o_push        = 1'b1;
            end else if (r_source_left != '0) begin
                // data without an open row is dropped here
                n_source_left = dec_left;
                o_push        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_left <= '0;
        end else begin
            r_source_left <= n_source_left;
        end
    end

endmodule

### sv/pbd_queue.sv
// ----------------------------------------------------------------------------
// pbd_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module pbd_queue import pbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (do_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### sv/pbd_back.sv
// ----------------------------------------------------------------------------
// pbd_back
// runs the header, literal and repeat phases and holds the output item
// ----------------------------------------------------------------------------
module pbd_back import pbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_word_units,
    input  logic [RowW-1:0]  i_row_length,
    input  logic             i_q_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [PatW-1:0]  o_pattern,
    output logic [WbW-1:0]   o_write_bytes,
    output logic             o_row_done
);

    t_phase            r_phase, n_phase;
    logic [LitW-1:0]   r_literal_left, n_literal_left;
    logic [ByteW-1:0]  r_repeat_units, n_repeat_units;
    logic [ByteW-1:0]  r_held_byte, n_held_byte;
    logic [RowW-1:0]   r_dest_left, n_dest_left;
    logic              r_halted, n_halted;

    logic              r_out_valid;
    logic [PatW-1:0]   r_pattern;
    logic [WbW-1:0]    r_write_bytes;
    logic              r_row_done;

    logic [PatW-1:0]   pat;
    logic [WbW-1:0]    wb;
    logic [LitW-1:0]   lit_w;
    logic [1:0]        unit_w;
    logic [RowW-1:0]   run_w;
    logic [RowW-1:0]   half_room;
    logic [ByteW-1:0]  pairs;
    logic [LitW-1:0]   lit_after;
    logic              emit;
    logic [ByteW-1:0]  b;

    assign b      = i_cmd.data;
    assign o_pop  = i_q_valid && (!r_out_valid || !i_out_stall);
    assign lit_w  = (LitW'(b) + LitW'(1)) << i_word_units;
    assign unit_w = i_word_units ? 2'd2 : 2'd1;
    assign half_room = r_dest_left >> 1;

    always_comb begin
        n_phase        = r_phase;
        n_literal_left = r_literal_left;
        n_repeat_units = r_repeat_units;
        n_held_byte    = r_held_byte;
        n_dest_left    = r_dest_left;
        n_halted       = r_halted;
        pat            = '0;
        wb             = '0;
        run_w          = '0;
        pairs          = '0;
        lit_after      = r_literal_left;
        if (o_pop) begin
            if (i_cmd.is_start) begin
                n_phase        = PH_HEADER;
                n_literal_left = '0;
                n_repeat_units = '0;
                n_held_byte    = '0;
                n_dest_left    = i_row_length;
                n_halted       = 1'b0;
            end else if (!r_halted) begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_dest_left == '0) begin
                            n_halted = 1'b1;
                        end else if (!b[ByteW-1]) begin
                            // literal that would overrun the packed bytes stops the row
                            if (CountW'(lit_w) > i_cmd.src_left) begin
                                n_halted = 1'b1;
                            end else begin
                                n_literal_left = lit_w;
                                n_phase        = PH_LITERAL;
                            end
                        end else if (b != HdrNop) begin
                            n_repeat_units = ByteW'(9'd257 - {1'b0, b});
                            if (CountW'(unit_w) > i_cmd.src_left) begin
                                n_halted = 1'b1;
                            end else begin
                                n_phase = PH_REPEAT;
                            end
                        end
                    end
                    PH_LITERAL: begin
                        if (r_dest_left != '0) begin
                            pat         = {b, b};
                            wb          = WbW'(1);
                            n_dest_left = r_dest_left - RowW'(1);
                        end
                        if (r_literal_left != '0) begin
                            lit_after = r_literal_left - LitW'(1);
                        end
                        n_literal_left = lit_after;
                        if (lit_after == '0) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    PH_REPEAT: begin
                        if (!i_word_units) begin
                            run_w = (RowW'(r_repeat_units) < r_dest_left) ?
                                    RowW'(r_repeat_units) : r_dest_left;
                            pat         = {b, b};
                            wb          = WbW'(run_w);
                            n_dest_left = r_dest_left - run_w;
                            n_phase     = PH_HEADER;
                        end else begin
                            n_held_byte = b;
                            n_phase     = PH_WORD2;
                        end
                    end
                    PH_WORD2: begin
                        // whole pairs only, odd room stays for a later literal
                        pairs = (RowW'(r_repeat_units) < half_room) ?
                                r_repeat_units : ByteW'(half_room);
                        pat         = {r_held_byte, b};
                        wb          = {pairs, 1'b0};
                        n_dest_left = r_dest_left - RowW'(wb);
                        n_phase     = PH_HEADER;
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end
        if (wb == '0) begin
            pat = '0;
        end
    end

    assign emit = o_pop && !i_cmd.is_start && ((wb != '0) || i_cmd.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_literal_left <= '0;
            r_repeat_units <= '0;
            r_held_byte    <= '0;
            r_dest_left    <= '0;
            r_halted       <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_literal_left <= n_literal_left;
            r_repeat_units <= n_repeat_units;
            r_held_byte    <= n_held_byte;
            r_dest_left    <= n_dest_left;
            r_halted       <= n_halted;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pattern     <= pat;
            r_write_bytes <= wb;
            r_row_done    <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pattern     = r_pattern;
    assign o_write_bytes = r_write_bytes;
    assign o_row_done    = r_row_done;

endmodule

### sv/packbits_run_decoder.sv
// ----------------------------------------------------------------------------
// packbits_run_decoder
// packbits scanline decoder producing run descriptors in byte or word units
// ----------------------------------------------------------------------------
// a result item is registered in the queue, then in the output register
// one item per cycle unless stalled; the decode state updates once per packed byte
// the two-entry queue between front and back lets each side stall on its own
// reset: synchronous active-low i_rst_n; queue empty, no row open, config cleared
// ----------------------------------------------------------------------------
module packbits_run_decoder import pbd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_req_type,
    input  logic [CountW-1:0]   i_packed_count,
    input  logic [ByteW-1:0]    i_packed_byte,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [PatW-1:0]     o_pattern,
    output logic [WbW-1:0]      o_write_bytes,
    output logic                o_row_done,
    // configuration write port
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_wdata
);

    // configuration registers, read live by the back end
    logic             r_word_units;
    logic [RowW-1:0]  r_row_length;

    // front to queue
    logic q_push;
    t_cmd q_in_cmd;
    logic q_full;

    // queue to back
    logic q_pop;
    logic q_valid;
    t_cmd q_out_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_units <= 1'b0;
            r_row_length <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CfgWordUnits: r_word_units <= i_cfg_wdata[0];
                CfgRowLength: r_row_length <= i_cfg_wdata[RowW-1:0];
                default: begin
                    r_word_units <= r_word_units;
                end
            endcase
        end
    end

    // front: counts packed bytes, drops data outside a row, flags the last byte
    pbd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_packed_count (i_packed_count),
        .i_packed_byte  (i_packed_byte),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_cmd          (q_in_cmd)
    );

    // short queue decoupling the two sides
    pbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    // back: header/literal/repeat state machine plus output register
    pbd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word_units  (r_word_units),
        .i_row_length  (r_row_length),
        .i_q_valid     (q_valid),
        .i_cmd         (q_out_cmd),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pattern     (o_pattern),
        .o_write_bytes (o_write_bytes),
        .o_row_done    (o_row_done)
    );

endmodule
